>>> hdl/sfla_pkg.sv
`default_nettype none

package sfla_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_W = 6;
  localparam int LINK_W = 7;
  localparam int CNT_W = 7;
  localparam int CMD_W = 2;
  localparam int STAT_W = 2;
  localparam int UOP_W = 4;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;

  localparam logic [UOP_W-1:0] U_NOP = 4'd0;
  localparam logic [UOP_W-1:0] U_INIT = 4'd1;
  localparam logic [UOP_W-1:0] U_A_RD = 4'd2;
  localparam logic [UOP_W-1:0] U_A_WR = 4'd3;
  localparam logic [UOP_W-1:0] U_A_FIN = 4'd4;
  localparam logic [UOP_W-1:0] U_F_RD = 4'd5;
  localparam logic [UOP_W-1:0] U_F_WR = 4'd6;
  localparam logic [UOP_W-1:0] U_F_FIN = 4'd7;
  localparam logic [UOP_W-1:0] U_E_NOFREE = 4'd8;
  localparam logic [UOP_W-1:0] U_E_BADFREE = 4'd9;
  localparam logic [UOP_W-1:0] U_L_START = 4'd10;
  localparam logic [UOP_W-1:0] U_L_EMIT = 4'd11;
  localparam logic [UOP_W-1:0] U_L_NEXT = 4'd12;

  typedef struct packed {
    logic             latch;
    logic [UOP_W-1:0] uop;
  } sfla_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             free_avail;
    logic             slot_used;
    logic             init_last;
    logic             list_last;
    logic             out_free;
  } sfla_stat_t;

endpackage

`default_nettype wire

>>> hdl/sfla_if.sv
`default_nettype none

interface sfla_in_if;
  logic                        valid;
  logic                        ready;
  logic [sfla_pkg::CMD_W-1:0]  command;
  logic [sfla_pkg::SLOT_W-1:0] slot;

  modport source (output valid, output command, output slot, input ready);
  modport sink (input valid, input command, input slot, output ready);
endinterface

interface sfla_out_if;
  logic                        valid;
  logic                        ready;
  logic [sfla_pkg::SLOT_W-1:0] slot_out;
  logic                        valid_res;
  logic [sfla_pkg::STAT_W-1:0] status;
  logic                        last;
  logic [sfla_pkg::CNT_W-1:0]  used_count;

  modport source (output valid, output slot_out, output valid_res, output status,
                  output last, output used_count, input ready);
  modport sink (input valid, input slot_out, input valid_res, input status,
                input last, input used_count, output ready);
endinterface

`default_nettype wire

>>> hdl/sfla_datapath.sv
`default_nettype none

module sfla_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sfla_pkg::sfla_ctl_t         ctl,
  output sfla_pkg::sfla_stat_t             stat,
  input  wire logic [sfla_pkg::CMD_W-1:0]  in_command,
  input  wire logic [sfla_pkg::SLOT_W-1:0] in_slot,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [sfla_pkg::SLOT_W-1:0]      out_slot_out,
  output logic                             out_valid_res,
  output logic [sfla_pkg::STAT_W-1:0]      out_status,
  output logic                             out_last,
  output logic [sfla_pkg::CNT_W-1:0]       out_used_count
);

  localparam int IDX_W = sfla_pkg::IDX_W;
  localparam int LINK_W = sfla_pkg::LINK_W;
  localparam int SLOT_W = sfla_pkg::SLOT_W;
  localparam int CNT_W = sfla_pkg::CNT_W;
  localparam int SLOTS = sfla_pkg::SLOTS;

  logic [LINK_W-1:0] next_mem [SLOTS];
  logic [LINK_W-1:0] prev_mem [SLOTS];
  logic              in_use_mem [SLOTS];

  logic [sfla_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [SLOT_W-1:0] sel_r, sel_nxt;
  logic [LINK_W-1:0] free_head_r, free_head_nxt;
  logic [LINK_W-1:0] used_head_r, used_head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] init_idx_r, init_idx_nxt;
  logic [IDX_W-1:0] list_idx_r, list_idx_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  logic [LINK_W-1:0] next_q_r, prev_q_r;
  logic used_q_r;

  logic out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic out_vres_r, out_vres_nxt;
  logic [sfla_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic out_last_r, out_last_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  logic [IDX_W-1:0] sel_idx;
  logic [LINK_W-1:0] sel_link;
  logic sel_ok, fh_ok, uh_ok, cur_ok, p_ok, n_ok;
  logic emit;

  logic rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic next_we, prev_we;
  logic [IDX_W-1:0] next_waddr, prev_waddr;
  logic [LINK_W-1:0] next_wdata, prev_wdata;
  logic use_we;
  logic [IDX_W-1:0] use_waddr;
  logic use_wdata;

  assign sel_idx = sel_r[IDX_W-1:0];
  assign sel_link = LINK_W'(sel_r);
  assign sel_ok = sel_link < sfla_pkg::NIL;
  assign fh_ok = free_head_r < sfla_pkg::NIL;
  assign uh_ok = used_head_r < sfla_pkg::NIL;
  assign cur_ok = cur_r < sfla_pkg::NIL;
  assign p_ok = prev_q_r < sfla_pkg::NIL;
  assign n_ok = next_q_r < sfla_pkg::NIL;

  assign stat.cmd = cmd_r;
  assign stat.free_avail = fh_ok;
  assign stat.slot_used = sel_ok && used_q_r;
  assign stat.init_last = init_idx_r == IDX_W'(SLOTS - 1);
  assign stat.list_last = list_idx_r == IDX_W'(SLOTS - 1);
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    rd_en = 1'b0;
    rd_addr = sel_idx;
    next_we = 1'b0;
    next_waddr = sel_idx;
    next_wdata = used_head_r;
    prev_we = 1'b0;
    prev_waddr = sel_idx;
    prev_wdata = sfla_pkg::NIL;
    use_we = 1'b0;
    use_waddr = sel_idx;
    use_wdata = 1'b0;
    case (ctl.uop)
      sfla_pkg::U_INIT: begin
        next_we = 1'b1;
        next_waddr = init_idx_r;
        next_wdata = (init_idx_r == IDX_W'(SLOTS - 1)) ? sfla_pkg::NIL :
                     LINK_W'(init_idx_r) + LINK_W'(1);
        use_we = 1'b1;
        use_waddr = init_idx_r;
      end
      sfla_pkg::U_A_RD: begin
        rd_en = 1'b1;
        rd_addr = free_head_r[IDX_W-1:0];
      end
      sfla_pkg::U_A_WR: begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      sfla_pkg::U_A_FIN: begin
        prev_we = uh_ok;
        prev_waddr = used_head_r[IDX_W-1:0];
        prev_wdata = sel_link;
        use_we = 1'b1;
        use_wdata = 1'b1;
      end
      sfla_pkg::U_F_RD: begin
        rd_en = 1'b1;
      end
      sfla_pkg::U_F_WR: begin
        next_we = p_ok;
        next_waddr = prev_q_r[IDX_W-1:0];
        next_wdata = next_q_r;
        prev_we = n_ok;
        prev_waddr = next_q_r[IDX_W-1:0];
        prev_wdata = prev_q_r;
      end
      sfla_pkg::U_F_FIN: begin
        next_we = 1'b1;
        next_wdata = free_head_r;
        use_we = 1'b1;
      end
      sfla_pkg::U_L_EMIT: begin
        rd_en = cur_ok;
        rd_addr = cur_r[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd_nxt = cmd_r;
    sel_nxt = sel_r;
    free_head_nxt = free_head_r;
    used_head_nxt = used_head_r;
    count_nxt = count_r;
    init_idx_nxt = init_idx_r;
    list_idx_nxt = list_idx_r;
    cur_nxt = cur_r;
    emit = 1'b0;
    out_slot_nxt = out_slot_r;
    out_vres_nxt = 1'b0;
    out_status_nxt = sfla_pkg::ST_OK;
    out_last_nxt = 1'b1;
    if (ctl.latch) begin
      cmd_nxt = in_command;
      sel_nxt = in_slot;
    end
    case (ctl.uop)
      sfla_pkg::U_INIT: begin
        init_idx_nxt = init_idx_r + IDX_W'(1);
      end
      sfla_pkg::U_A_RD: begin
        sel_nxt = free_head_r[SLOT_W-1:0];
      end
      sfla_pkg::U_A_WR: begin
        free_head_nxt = next_q_r;
      end
      sfla_pkg::U_A_FIN: begin
        used_head_nxt = sel_link;
        count_nxt = count_r + CNT_W'(1);
        emit = 1'b1;
        out_slot_nxt = sel_r;
        out_vres_nxt = 1'b1;
      end
      sfla_pkg::U_F_WR: begin
        if (!p_ok) begin
          used_head_nxt = next_q_r;
        end
      end
      sfla_pkg::U_F_FIN: begin
        free_head_nxt = sel_link;
        count_nxt = count_r - CNT_W'(1);
        emit = 1'b1;
        out_slot_nxt = sel_r;
      end
      sfla_pkg::U_E_NOFREE: begin
        emit = 1'b1;
        out_slot_nxt = '0;
        out_status_nxt = sfla_pkg::ST_NOFREE;
      end
      sfla_pkg::U_E_BADFREE: begin
        emit = 1'b1;
        out_slot_nxt = sel_r;
        out_status_nxt = sfla_pkg::ST_BADFREE;
      end
      sfla_pkg::U_L_START: begin
        cur_nxt = used_head_r;
        list_idx_nxt = '0;
      end
      sfla_pkg::U_L_EMIT: begin
        emit = 1'b1;
        out_slot_nxt = cur_ok ? cur_r[SLOT_W-1:0] : '0;
        out_vres_nxt = cur_ok;
        out_last_nxt = stat.list_last;
        list_idx_nxt = list_idx_r + IDX_W'(1);
      end
      sfla_pkg::U_L_NEXT: begin
        if (cur_ok) begin
          cur_nxt = next_q_r;
        end
      end
      default: begin
      end
    endcase
    out_count_nxt = count_nxt;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      used_head_r <= sfla_pkg::NIL;
      count_r <= '0;
      init_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      free_head_r <= free_head_nxt;
      used_head_r <= used_head_nxt;
      count_r <= count_nxt;
      init_idx_r <= init_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    sel_r <= sel_nxt;
    list_idx_r <= list_idx_nxt;
    cur_r <= cur_nxt;
    if (emit) begin
      out_slot_r <= out_slot_nxt;
      out_vres_r <= out_vres_nxt;
      out_status_r <= out_status_nxt;
      out_last_r <= out_last_nxt;
      out_count_r <= out_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (rd_en) begin
      next_q_r <= next_mem[rd_addr];
      prev_q_r <= prev_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (use_we) begin
      in_use_mem[use_waddr] <= use_wdata;
    end
    if (ctl.latch) begin
      used_q_r <= in_use_mem[in_slot[IDX_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_slot_out = out_slot_r;
  assign out_valid_res = out_vres_r;
  assign out_status = out_status_r;
  assign out_last = out_last_r;
  assign out_used_count = out_count_r;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOTS))
    else $error("Used count exceeds the number of slots.");

  a_alloc_pushes_used: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.uop == sfla_pkg::U_A_FIN) |=>
      (used_head_r == $past(sel_link)) && (count_r == $past(count_r) + CNT_W'(1)))
    else $error("Allocated slot did not become the used list head.");

  a_free_pushes_head: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.uop == sfla_pkg::U_F_FIN) |=> (free_head_r == $past(sel_link)))
    else $error("Released slot did not become the free list head.");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=>
      out_valid_r && $stable(out_slot_r) && $stable(out_count_r))
    else $error("A waiting result changed before it was taken.");
`endif

endmodule

`default_nettype wire

>>> hdl/sfla_ctrl.sv
`default_nettype none

module sfla_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sfla_pkg::sfla_stat_t stat,
  output sfla_pkg::sfla_ctl_t       ctl
);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DEC = 4'd2;
  localparam logic [3:0] S_A_RD = 4'd3;
  localparam logic [3:0] S_A_WR = 4'd4;
  localparam logic [3:0] S_A_FIN = 4'd5;
  localparam logic [3:0] S_F_RD = 4'd6;
  localparam logic [3:0] S_F_WR = 4'd7;
  localparam logic [3:0] S_F_FIN = 4'd8;
  localparam logic [3:0] S_E_NOFREE = 4'd9;
  localparam logic [3:0] S_E_BADFREE = 4'd10;
  localparam logic [3:0] S_L_EMIT = 4'd11;
  localparam logic [3:0] S_L_NEXT = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    ctl.latch = 1'b0;
    ctl.uop = sfla_pkg::U_NOP;
    case (state_r)
      S_INIT: begin
        ctl.uop = sfla_pkg::U_INIT;
        if (stat.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        ctl.uop = sfla_pkg::U_L_START;
        case (stat.cmd)
          sfla_pkg::CMD_ALLOC: state_nxt = stat.free_avail ? S_A_RD : S_E_NOFREE;
          sfla_pkg::CMD_FREE: state_nxt = stat.slot_used ? S_F_RD : S_E_BADFREE;
          sfla_pkg::CMD_LIST: state_nxt = S_L_EMIT;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_A_RD: begin
        ctl.uop = sfla_pkg::U_A_RD;
        state_nxt = S_A_WR;
      end
      S_A_WR: begin
        ctl.uop = sfla_pkg::U_A_WR;
        state_nxt = S_A_FIN;
      end
      S_A_FIN: begin
        if (stat.out_free) begin
          ctl.uop = sfla_pkg::U_A_FIN;
          state_nxt = S_IDLE;
        end
      end
      S_F_RD: begin
        ctl.uop = sfla_pkg::U_F_RD;
        state_nxt = S_F_WR;
      end
      S_F_WR: begin
        ctl.uop = sfla_pkg::U_F_WR;
        state_nxt = S_F_FIN;
      end
      S_F_FIN: begin
        if (stat.out_free) begin
          ctl.uop = sfla_pkg::U_F_FIN;
          state_nxt = S_IDLE;
        end
      end
      S_E_NOFREE: begin
        if (stat.out_free) begin
          ctl.uop = sfla_pkg::U_E_NOFREE;
          state_nxt = S_IDLE;
        end
      end
      S_E_BADFREE: begin
        if (stat.out_free) begin
          ctl.uop = sfla_pkg::U_E_BADFREE;
          state_nxt = S_IDLE;
        end
      end
      S_L_EMIT: begin
        if (stat.out_free) begin
          ctl.uop = sfla_pkg::U_L_EMIT;
          state_nxt = stat.list_last ? S_IDLE : S_L_NEXT;
        end
      end
      S_L_NEXT: begin
        ctl.uop = sfla_pkg::U_L_NEXT;
        state_nxt = S_L_EMIT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/slot_free_list_allocator_unit.sv
// Slot allocator keeping the slots on a singly linked free list and a doubly linked used list.
// The links and the in-use flags sit in small memories with one write and one registered read
// per cycle. After reset the block runs a clearing pass over all SLOTS entries that chains the
// free list in index order and clears the in-use flags, and accepts no request until it ends.
// Requests are then taken one at a time: an allocate or a free steps through decode, one link
// read and two steps of link writes, and registers its result in the last of these; an error
// registers its result in the step after decode; a list presents SLOTS entries, an emit step per
// entry with a next step between entries, paced by one link read per step of the walk. A result
// that is not taken holds the block in its last step. The result register lets a new request be
// accepted while the previous result is still waiting to be taken.
`default_nettype none

module slot_free_list_allocator_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  sfla_in_if.sink   in_ch,
  sfla_out_if.source out_ch
);

  sfla_pkg::sfla_ctl_t  ctl;
  sfla_pkg::sfla_stat_t stat;

  sfla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  sfla_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .stat           (stat),
    .in_command     (in_ch.command),
    .in_slot        (in_ch.slot),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_slot_out   (out_ch.slot_out),
    .out_valid_res  (out_ch.valid_res),
    .out_status     (out_ch.status),
    .out_last       (out_ch.last),
    .out_used_count (out_ch.used_count)
  );

endmodule

`default_nettype wire

>>> dv/sfla_slot_tracker.sv
`timescale 1ns / 100ps

module sfla_slot_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  sfla_in_if                          in_ch,
  sfla_out_if                         out_ch,
  output int                          fail_count,
  output int                          pending,
  output int                          checked,
  output int                          nofree_seen,
  output int                          badfree_seen,
  output int                          peak_used,
  output logic [sfla_pkg::SLOTS-1:0]  busy_slots,
  output logic [sfla_pkg::CNT_W-1:0]  used_now
);
  import sfla_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              valid_res;
    logic [STAT_W-1:0] status;
    logic              last;
    logic [CNT_W-1:0]  used_count;
  } slot_result_t;

  slot_result_t      due_q[$];
  logic [LINK_W-1:0] fwd_link [SLOTS];
  logic [LINK_W-1:0] back_link [SLOTS];
  logic [SLOTS-1:0]  held;
  logic [LINK_W-1:0] free_top;
  logic [LINK_W-1:0] used_top;
  logic [CNT_W-1:0]  held_count;
  int                fails = 0;
  int                matched = 0;
  int                nofree_n = 0;
  int                badfree_n = 0;
  int                peak = 0;

  function automatic logic linked(input logic [LINK_W-1:0] lk);
    return lk < LINK_W'(SLOTS);
  endfunction

  task automatic queue_result(input logic [SLOT_W-1:0] s, input logic v,
                              input logic [STAT_W-1:0] st, input logic l);
    slot_result_t r;
    r.slot_out = s;
    r.valid_res = v;
    r.status = st;
    r.last = l;
    r.used_count = held_count;
    due_q.push_back(r);
  endtask

  task automatic clear_lists();
    for (int i = 0; i < SLOTS; i++) begin
      fwd_link[i] = (i == SLOTS - 1) ? NIL : LINK_W'(i + 1);
      back_link[i] = (i == 0) ? NIL : LINK_W'(i - 1);
    end
    held = '0;
    free_top = '0;
    used_top = NIL;
    held_count = '0;
    due_q.delete();
  endtask

  task automatic take_slot();
    logic [LINK_W-1:0] s;
    s = free_top;
    if (!linked(s)) begin
      queue_result('0, 1'b0, ST_NOFREE, 1'b1);
      nofree_n++;
    end else begin
      free_top = fwd_link[s[IDX_W-1:0]];
      if (linked(free_top)) back_link[free_top[IDX_W-1:0]] = NIL;
      fwd_link[s[IDX_W-1:0]] = used_top;
      if (linked(used_top)) back_link[used_top[IDX_W-1:0]] = s;
      back_link[s[IDX_W-1:0]] = NIL;
      used_top = s;
      held[s[IDX_W-1:0]] = 1'b1;
      held_count = held_count + 1'b1;
      queue_result(s[SLOT_W-1:0], 1'b1, ST_OK, 1'b1);
    end
  endtask

  task automatic release_slot(input logic [SLOT_W-1:0] s);
    logic [LINK_W-1:0] p;
    logic [LINK_W-1:0] n;
    if (!linked(LINK_W'(s)) || !held[s[IDX_W-1:0]]) begin
      queue_result(s, 1'b0, ST_BADFREE, 1'b1);
      badfree_n++;
    end else begin
      p = back_link[s[IDX_W-1:0]];
      n = fwd_link[s[IDX_W-1:0]];
      if (linked(p)) fwd_link[p[IDX_W-1:0]] = n;
      else used_top = n;
      if (linked(n)) back_link[n[IDX_W-1:0]] = p;
      back_link[s[IDX_W-1:0]] = NIL;
      fwd_link[s[IDX_W-1:0]] = free_top;
      if (linked(free_top)) back_link[free_top[IDX_W-1:0]] = LINK_W'(s);
      free_top = LINK_W'(s);
      held[s[IDX_W-1:0]] = 1'b0;
      held_count = held_count - 1'b1;
      queue_result(s, 1'b0, ST_OK, 1'b1);
    end
  endtask

  // A list request yields exactly SLOTS entries: used slots newest first, then blanks.
  task automatic walk_used();
    int                j;
    logic [LINK_W-1:0] p;
    j = 0;
    p = used_top;
    while (linked(p) && j < SLOTS) begin
      queue_result(p[SLOT_W-1:0], 1'b1, ST_OK, j == SLOTS - 1);
      p = fwd_link[p[IDX_W-1:0]];
      j++;
    end
    while (j < SLOTS) begin
      queue_result('0, 1'b0, ST_OK, j == SLOTS - 1);
      j++;
    end
  endtask

  task automatic note_fail(input string what, input slot_result_t want,
                           input slot_result_t got);
    fails++;
    if (fails <= 10)
      $display("%0t: %s: expected slot %0d valid %0b status %0d last %0b count %0d, got slot %0d valid %0b status %0d last %0b count %0d",
               $time, what, want.slot_out, want.valid_res, want.status, want.last,
               want.used_count, got.slot_out, got.valid_res, got.status, got.last,
               got.used_count);
  endtask

  always @(posedge clk) begin
    slot_result_t got;
    slot_result_t want;
    if (!rst_n) begin
      clear_lists();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.slot_out = out_ch.slot_out;
        got.valid_res = out_ch.valid_res;
        got.status = out_ch.status;
        got.last = out_ch.last;
        got.used_count = out_ch.used_count;
        if (due_q.size() == 0) begin
          note_fail("result with none outstanding", '0, got);
        end else begin
          want = due_q.pop_front();
          matched++;
          if (got !== want) note_fail("result mismatch", want, got);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.command)
          CMD_ALLOC: take_slot();
          CMD_FREE:  release_slot(in_ch.slot);
          CMD_LIST:  walk_used();
          default: ;
        endcase
      end
      if (int'(held_count) > peak) peak = int'(held_count);
    end
    fail_count <= fails;
    pending <= due_q.size();
    checked <= matched;
    nofree_seen <= nofree_n;
    badfree_seen <= badfree_n;
    peak_used <= peak;
    busy_slots <= held;
    used_now <= held_count;
  end

endmodule

>>> dv/slot_free_list_allocator_unit_tb.sv
`timescale 1ns / 100ps

module slot_free_list_allocator_unit_tb;

  localparam int SLOTS = sfla_pkg::SLOTS;
  localparam int SLOT_W = sfla_pkg::SLOT_W;
  localparam int CNT_W = sfla_pkg::CNT_W;
  localparam int CMD_W = sfla_pkg::CMD_W;
  localparam int LIMIT = 1_000_000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  sfla_in_if  in_ch ();
  sfla_out_if out_ch ();

  int               fail_count;
  int               pending;
  int               checked;
  int               nofree_seen;
  int               badfree_seen;
  int               peak_used;
  logic [SLOTS-1:0] busy_slots;
  logic [CNT_W-1:0] used_now;

  int   cycles = 0;
  int   calm_left = 0;
  int   ready_run = 0;
  logic ready_nxt = 1'b0;
  int   n_alloc = 0;
  int   n_free = 0;
  int   n_list = 0;
  int   n_ignored = 0;

  slot_free_list_allocator_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sfla_slot_tracker tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .nofree_seen  (nofree_seen),
    .badfree_seen (badfree_seen),
    .peak_used    (peak_used),
    .busy_slots   (busy_slots),
    .used_now     (used_now)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("slot_free_list_allocator_unit_tb: FAIL");
      $finish;
    end
  end

  // The result side alternates bursts of acceptance with stalls, some of them long.
  always @(posedge clk) begin
    int r;
    if (ready_run > 0) begin
      ready_run--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        ready_nxt = 1'b1;
        ready_run = $urandom_range(30, 120);
      end else if (r < 60) begin
        ready_nxt = 1'b1;
        ready_run = $urandom_range(1, 6);
      end else if (r < 92) begin
        ready_nxt = 1'b0;
        ready_run = $urandom_range(1, 3);
      end else begin
        ready_nxt = 1'b0;
        ready_run = $urandom_range(8, 20);
      end
    end
    out_ch.ready <= ready_nxt;
  end

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [SLOT_W-1:0] pick_used();
    int k;
    k = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < SLOTS; i++)
      if (busy_slots[(k + i) % SLOTS]) return SLOT_W'((k + i) % SLOTS);
    return SLOT_W'($urandom_range(0, SLOTS - 1));
  endfunction

  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.slot <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (cmd)
      sfla_pkg::CMD_ALLOC: n_alloc++;
      sfla_pkg::CMD_FREE:  n_free++;
      sfla_pkg::CMD_LIST:  n_list++;
      default:             n_ignored++;
    endcase
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly well-formed requests (frees name slots believed to be in use); the rest is noise.
  task automatic random_req(input int p_alloc, input int p_free, input int p_list);
    int r;
    r = $urandom_range(0, 99);
    if (r < p_alloc) send_req(sfla_pkg::CMD_ALLOC, SLOT_W'($urandom));
    else if (r < p_alloc + p_free) send_req(sfla_pkg::CMD_FREE, pick_used());
    else if (r < p_alloc + p_free + p_list) send_req(sfla_pkg::CMD_LIST, SLOT_W'($urandom));
    else if ($urandom_range(0, 1) == 0) send_req(sfla_pkg::CMD_FREE, SLOT_W'($urandom));
    else send_req(CMD_UNUSED, SLOT_W'($urandom));
  endtask

  initial begin
    int to_fill;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= sfla_pkg::CMD_ALLOC;
    in_ch.slot <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_req(sfla_pkg::CMD_ALLOC, 6'd0);
    send_req(sfla_pkg::CMD_FREE, 6'd5);
    send_req(sfla_pkg::CMD_LIST, 6'd0);
    send_req(sfla_pkg::CMD_FREE, 6'd0);
    send_req(sfla_pkg::CMD_FREE, 6'd0);
    repeat (4) send_req(sfla_pkg::CMD_ALLOC, 6'd0);
    send_req(sfla_pkg::CMD_LIST, 6'd0);
    send_req(sfla_pkg::CMD_FREE, 6'd2);
    send_req(sfla_pkg::CMD_FREE, 6'd3);
    send_req(sfla_pkg::CMD_FREE, 6'd0);
    send_req(sfla_pkg::CMD_LIST, 6'd63);
    send_req(sfla_pkg::CMD_FREE, 6'd63);
    send_req(sfla_pkg::CMD_FREE, 6'd1);
    send_req(CMD_UNUSED, 6'd63);
    send_req(CMD_UNUSED, 6'd0);
    send_req(sfla_pkg::CMD_ALLOC, 6'd63);
    send_req(sfla_pkg::CMD_LIST, 6'd0);
    send_req(sfla_pkg::CMD_FREE, 6'd1);

    repeat (80) random_req(85, 8, 4);
    quiesce();
    to_fill = SLOTS - int'(used_now);
    repeat (to_fill) send_req(sfla_pkg::CMD_ALLOC, SLOT_W'($urandom));
    repeat (2) send_req(sfla_pkg::CMD_ALLOC, SLOT_W'($urandom));
    send_req(sfla_pkg::CMD_LIST, SLOT_W'($urandom));
    quiesce();

    repeat (60) random_req(5, 80, 5);
    quiesce();
    repeat (55) random_req(40, 40, 10);
    send_req(sfla_pkg::CMD_LIST, SLOT_W'($urandom));

    quiesce();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests: %0d allocate, %0d free, %0d list, %0d with the unused code.",
             n_alloc + n_free + n_list + n_ignored, n_alloc, n_free, n_list, n_ignored);
    $display("Checked %0d results; peak occupancy %0d of %0d, %0d no-free and %0d bad-free.",
             checked, peak_used, SLOTS, nofree_seen, badfree_seen);
    if (fail_count == 0) begin
      $display("slot_free_list_allocator_unit_tb: PASS");
    end else begin
      $display("%0d failures.", fail_count);
      $display("slot_free_list_allocator_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/sfla_pkg.sv
hdl/sfla_if.sv
hdl/sfla_datapath.sv
hdl/sfla_ctrl.sv
hdl/slot_free_list_allocator_unit.sv
dv/sfla_slot_tracker.sv
dv/slot_free_list_allocator_unit_tb.sv
